// ===== hdl/stt_pkg.sv =====
// Shared types, sizes and codes for the software timer slot table.
// No dependencies; every other file in hdl/ imports this package.
package stt_pkg;

  localparam int unsigned SLOTS       = 4;
  localparam int unsigned MAX_RESULTS = 4;

  localparam int unsigned SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_RESULTS + 1);

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned DELAY_W  = 31;
  localparam int unsigned ID_W     = 8;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned SLOT_W   = 2;

  typedef logic [SLOT_IDX_W-1:0] slot_idx_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_TICK   = 2'd0,
    ACT_ONCE   = 2'd1,
    ACT_REPEAT = 2'd2
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_FIRED  = 2'd0,
    KIND_PLACED = 2'd1,
    KIND_FULL   = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [TIME_W-1:0]  deadline;
    logic [DELAY_W-1:0] period;
    logic               repeats;
    logic [ID_W-1:0]    cb_id;
  } slot_entry_t;

  typedef struct packed {
    logic              we;
    slot_idx_t         addr;
    slot_entry_t       data;
  } ram_wr_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   fired_id;
    logic              last;
  } res_item_t;

  typedef struct packed {
    logic      valid;
    res_item_t item;
  } push_t;

  // Result slot field carries the low bits of the slot index
  function automatic logic [SLOT_W-1:0] slot_field(slot_idx_t idx);
    logic [31:0] wide;
    wide = 32'(idx);
    return wide[SLOT_W-1:0];
  endfunction

endpackage

// ===== hdl/stt_if.sv =====
// Request and result channel interfaces (valid/ready) of the timer slot table.
// Depends on stt_pkg for field widths.
interface stt_req_if import stt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [TIME_W-1:0]   time_now;
  logic [DELAY_W-1:0]  delay_ms;
  logic [ID_W-1:0]     callback_id;

  modport source (output valid, action, time_now, delay_ms, callback_id, input ready);
  modport sink   (input valid, action, time_now, delay_ms, callback_id, output ready);
endinterface

interface stt_res_if import stt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0]   fired_id;
  logic              last;

  modport source (output valid, kind, slot, fired_id, last, input ready);
  modport sink   (input valid, kind, slot, fired_id, last, output ready);
endinterface

// ===== hdl/software_timer_slot_table_unit.sv =====
// Timer slot table. A schedule request yields one result.
// A tick request reads the slot memory once per slot in turn, then releases the
// final result in the flush state; output stalls can hold the scan and the flush.
// One request at a time. Results pass through the output register after they are
// formed. Reset (async, active low) frees every slot; no sweep.
module software_timer_slot_table_unit import stt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  stt_req_if.sink    req_i,
  stt_res_if.source  res_o
);

  push_t       push;
  logic        push_ready;
  ram_wr_t     ram_wr;
  slot_idx_t   ram_raddr;
  slot_entry_t ram_rdata;

  stt_sequencer u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .push_o       (push),
    .push_ready_i (push_ready),
    .ram_wr_o     (ram_wr),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (ram_rdata)
  );

  stt_slot_ram u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  stt_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .res_o        (res_o)
  );

endmodule

// ===== hdl/stt_slot_ram.sv =====
// Slot memory: one write port, one read port with registered read data.
// Depends on stt_pkg; contents are undefined until written.
module stt_slot_ram import stt_pkg::*; (
  input  logic        clk_i,
  input  ram_wr_t     wr_i,
  input  slot_idx_t   raddr_i,
  output slot_entry_t rdata_o
);

  slot_entry_t mem_q [SLOTS];
  slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/stt_out_reg.sv =====
// Output register for results: decouples the sequencer from the result sink.
// Depends on stt_pkg and stt_if.
module stt_out_reg import stt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  output logic             push_ready_o,
  stt_res_if.source        res_o
);

  logic      valid_q, valid_d;
  res_item_t item_q;

  assign push_ready_o = !valid_q || res_o.ready;

  always_comb begin
    valid_d = valid_q;
    if (res_o.ready) begin
      valid_d = 1'b0;
    end
    if (push_i.valid) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid && push_ready_o) begin
      item_q <= push_i.item;
    end
  end

  assign res_o.valid    = valid_q;
  assign res_o.kind     = item_q.kind;
  assign res_o.slot     = item_q.slot;
  assign res_o.fired_id = item_q.fired_id;
  assign res_o.last     = item_q.last;

endmodule

// ===== hdl/stt_sequencer.sv =====
// Request sequencer: slot allocation, tick scan over the slot memory and result
// ordering with the last mark. Depends on stt_pkg and stt_if.
module stt_sequencer import stt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  stt_req_if.sink     req_i,
  output push_t       push_o,
  input  logic        push_ready_i,
  output ram_wr_t     ram_wr_o,
  output slot_idx_t   ram_raddr_o,
  input  slot_entry_t ram_rdata_i
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  localparam slot_idx_t LAST_IDX  = SLOT_IDX_W'(SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

  logic [1:0]        state_q, state_d;
  slot_idx_t         ev_idx_q, ev_idx_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              held_valid_q, held_valid_d;
  slot_idx_t         held_idx_q, held_idx_d;
  logic [ID_W-1:0]   held_id_q, held_id_d;
  logic [SLOTS-1:0]  valid_q, valid_d;

  logic      free_found;
  slot_idx_t free_idx;
  logic      due, emit_held, stall;
  slot_idx_t ev_next;

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = SLOT_IDX_W'(i);
      end
    end
  end

  assign due       = (state_q == S_SCAN) && valid_q[ev_idx_q]
                     && (ram_rdata_i.deadline < now_q);
  assign emit_held = due && held_valid_q;
  assign stall     = emit_held && !push_ready_i;
  assign ev_next   = (ev_idx_q == LAST_IDX) ? '0 : ev_idx_q + 1'b1;

  always_comb begin
    state_d      = state_q;
    ev_idx_d     = ev_idx_q;
    now_d        = now_q;
    cnt_d        = cnt_q;
    held_valid_d = held_valid_q;
    held_idx_d   = held_idx_q;
    held_id_d    = held_id_q;
    valid_d      = valid_q;

    ram_wr_o.we   = 1'b0;
    ram_wr_o.addr = ev_idx_q;
    ram_wr_o.data = ram_rdata_i;
    ram_raddr_o   = '0;

    push_o.valid = 1'b0;
    push_o.item  = '0;
    req_i.ready  = 1'b0;

    case (state_q)
      S_IDLE: begin
        req_i.ready = push_ready_i;
        if (req_i.valid && push_ready_i) begin
          case (req_i.action)
            ACT_TICK: begin
              now_d        = req_i.time_now;
              ev_idx_d     = '0;
              cnt_d        = '0;
              held_valid_d = 1'b0;
              state_d      = S_SCAN;
            end
            ACT_ONCE, ACT_REPEAT: begin
              push_o.valid         = 1'b1;
              push_o.item.fired_id = req_i.callback_id;
              push_o.item.last     = 1'b1;
              if (free_found) begin
                ram_wr_o.we                 = 1'b1;
                ram_wr_o.addr               = free_idx;
                ram_wr_o.data.deadline      = req_i.time_now + TIME_W'(req_i.delay_ms);
                ram_wr_o.data.period        = req_i.delay_ms;
                ram_wr_o.data.repeats       = (req_i.action == ACT_REPEAT);
                ram_wr_o.data.cb_id         = req_i.callback_id;
                valid_d[free_idx]           = 1'b1;
                push_o.item.kind            = KIND_PLACED;
                push_o.item.slot            = slot_field(free_idx);
              end else begin
                push_o.item.kind = KIND_FULL;
              end
            end
            default: ;
          endcase
        end
      end

      S_SCAN: begin
        ram_raddr_o = stall ? ev_idx_q : ev_next;
        if (emit_held && push_ready_i) begin
          push_o.valid         = 1'b1;
          push_o.item.kind     = KIND_FIRED;
          push_o.item.slot     = slot_field(held_idx_q);
          push_o.item.fired_id = held_id_q;
        end
        if (!stall) begin
          if (due) begin
            held_valid_d = 1'b1;
            held_idx_d   = ev_idx_q;
            held_id_d    = ram_rdata_i.cb_id;
            cnt_d        = cnt_q + 1'b1;
            if (ram_rdata_i.repeats) begin
              // re-arm in place
              ram_wr_o.we            = 1'b1;
              ram_wr_o.data.deadline = now_q + TIME_W'(ram_rdata_i.period);
            end else begin
              valid_d[ev_idx_q] = 1'b0;
            end
          end
          if ((ev_idx_q == LAST_IDX) || (due && (cnt_q == CNT_LAST))) begin
            state_d = S_FLUSH;
          end else begin
            ev_idx_d = ev_next;
          end
        end
      end

      S_FLUSH: begin
        push_o.valid     = 1'b1;
        push_o.item.last = 1'b1;
        if (held_valid_q) begin
          push_o.item.kind     = KIND_FIRED;
          push_o.item.slot     = slot_field(held_idx_q);
          push_o.item.fired_id = held_id_q;
        end else begin
          push_o.item.kind = KIND_NONE;
        end
        if (push_ready_i) begin
          held_valid_d = 1'b0;
          state_d      = S_IDLE;
        end else begin
          push_o.valid = 1'b0;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      held_valid_q <= 1'b0;
      valid_q      <= '0;
      ev_idx_q     <= '0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      held_valid_q <= held_valid_d;
      valid_q      <= valid_d;
      ev_idx_q     <= ev_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    held_idx_q <= held_idx_d;
    held_id_q  <= held_id_d;
  end

  // A result is only offered when the output register can take it
  a_push_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o.valid |-> push_ready_i)
    else $error("result offered while output register is full");

  // Write-back during a scan never hits the entry being read in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_wr_o.we && state_q == S_SCAN) |-> (ram_wr_o.addr != ram_raddr_o))
    else $error("scan write-back collides with the read address");

  // Fired count stays within the per-tick limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_RESULTS))
    else $error("fired count beyond limit");

  // A placed request leaves its slot occupied
  a_placed_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && push_o.valid && push_o.item.kind == KIND_PLACED)
    |=> valid_q[$past(free_idx)])
    else $error("placed slot not marked occupied");

  // A fired one-shot slot is freed
  a_oneshot_freed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due && !stall && !ram_rdata_i.repeats) |=> !valid_q[$past(ev_idx_q)])
    else $error("one-shot slot still occupied after firing");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for software_timer_slot_table_unit: directed and random
// schedule and tick requests, checked against a behavioural slot table model.
// Depends on hdl/stt_pkg.sv, hdl/stt_if.sv and the unit itself.
`timescale 1ns / 1ps

module tb_top import stt_pkg::*; ;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 210;
  localparam int unsigned STALL_LIMIT  = 5000;

  // Behavioural copy of the slot table plus the queue of results still owed
  class timer_table_tracker;
    bit                 armed    [SLOTS];
    logic [TIME_W-1:0]  deadline [SLOTS];
    logic [DELAY_W-1:0] period   [SLOTS];
    bit                 repeats  [SLOTS];
    logic [ID_W-1:0]    cb_id    [SLOTS];
    res_item_t          awaited_results [$];
    int unsigned        mismatches;

    function void note_request(logic [ACTION_W-1:0] act, logic [TIME_W-1:0] now,
                               logic [DELAY_W-1:0] delay, logic [ID_W-1:0] id);
      res_item_t hits [MAX_RESULTS];
      res_item_t item;
      int        n;
      int        free_slot;
      n         = 0;
      free_slot = -1;
      case (act)
        ACT_ONCE, ACT_REPEAT: begin
          for (int i = SLOTS - 1; i >= 0; i--)
            if (!armed[i]) free_slot = i;
          if (free_slot < 0) begin
            item = '{kind: KIND_FULL, slot: '0, fired_id: id, last: 1'b1};
          end else begin
            armed[free_slot]    = 1'b1;
            deadline[free_slot] = now + delay;
            period[free_slot]   = delay;
            repeats[free_slot]  = (act == ACT_REPEAT);
            cb_id[free_slot]    = id;
            item = '{kind: KIND_PLACED, slot: SLOT_W'(free_slot), fired_id: id, last: 1'b1};
          end
          awaited_results.push_back(item);
        end
        ACT_TICK: begin
          for (int i = 0; i < SLOTS && n < MAX_RESULTS; i++) begin
            if (armed[i] && deadline[i] < now) begin
              hits[n] = '{kind: KIND_FIRED, slot: SLOT_W'(i), fired_id: cb_id[i], last: 1'b0};
              n++;
              // re-arm repeating slots from the tick time, free one-shots
              if (repeats[i]) deadline[i] = now + period[i];
              else armed[i] = 1'b0;
            end
          end
          if (n == 0) begin
            item = '{kind: KIND_NONE, slot: '0, fired_id: '0, last: 1'b1};
            awaited_results.push_back(item);
          end else begin
            hits[n-1].last = 1'b1;
            for (int k = 0; k < n; k++) awaited_results.push_back(hits[k]);
          end
        end
        default: ; // unused action: no state change, no result
      endcase
    endfunction

    function void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
    endfunction

    function void check_result(res_item_t got);
      res_item_t want;
      if (awaited_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual kind %0d slot %0d id %0d last %0d",
                 $time, got.kind, got.slot, got.fired_id, got.last);
      end else begin
        want = awaited_results.pop_front();
        compare_field("kind", want.kind, got.kind);
        compare_field("slot", want.slot, got.slot);
        compare_field("fired_id", want.fired_id, got.fired_id);
        compare_field("last", want.last, got.last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni      = 1'b0;
  logic take_result = 1'b0;
  bit   steady      = 1'b0;
  int unsigned stall_left   = 0;
  int unsigned quiet_cycles = 0;

  timer_table_tracker tracker = new;

  stt_req_if req ();
  stt_res_if res ();

  software_timer_slot_table_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .res_o  (res)
  );

  assign res.ready = take_result;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one; none during a steady phase
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [TIME_W-1:0] now,
                              input logic [DELAY_W-1:0] delay, input logic [ID_W-1:0] id);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid       <= 1'b1;
    req.action      <= act;
    req.time_now    <= now;
    req.delay_ms    <= delay;
    req.callback_id <= id;
    do @(posedge clk_i); while (!req.ready);
  endtask

  // Result side back-pressure
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      take_result <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      take_result <= 1'b1;
      stall_left  <= pick_gap();
    end
  end

  // Note requests before checking results: a result never shares an edge with its request
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (req.valid && req.ready)
        tracker.note_request(req.action, req.time_now, req.delay_ms, req.callback_id);
      if (res.valid && res.ready)
        tracker.check_result(res_item_t'({res.kind, res.slot, res.fired_id, res.last}));
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (res.valid && res.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("%0t: no request or result moved for %0d cycles", $time, STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [TIME_W-1:0]   now_ms;
    logic [ACTION_W-1:0] act;
    logic [DELAY_W-1:0]  delay;
    int unsigned         counted;
    int unsigned         r;
    int unsigned         dr;

    req.valid       <= 1'b0;
    req.action      <= ACT_TICK;
    req.time_now    <= '0;
    req.delay_ms    <= '0;
    req.callback_id <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table, zero delay, strict compare at equal time
    send_request(ACT_TICK, 32'd0, 31'd0, 8'd0);
    send_request(ACT_ONCE, 32'd0, 31'd0, 8'd0);
    send_request(ACT_TICK, 32'd0, 31'd0, 8'd0);
    send_request(ACT_TICK, 32'd1, 31'd0, 8'd0);
    // Fill every slot, one repeating with a wrapping deadline
    send_request(ACT_ONCE, 32'd100, 31'd5, 8'hFF);
    send_request(ACT_ONCE, 32'd100, 31'h7FFF_FFFF, 8'hA5);
    send_request(ACT_REPEAT, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'h5A);
    send_request(ACT_ONCE, 32'd0, 31'd0, 8'h3C);
    // Table full for both schedule kinds, then an unused action
    send_request(ACT_ONCE, 32'h1234_5678, 31'h2AAA_AAAA, 8'h77);
    send_request(ACT_REPEAT, 32'h8765_4321, 31'h5555_5555, 8'h88);
    send_request(ACT_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
    // Every slot due at once, then the re-armed repeat
    send_request(ACT_TICK, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 8'hFF);
    send_request(ACT_TICK, 32'h7FFF_FFFE, 31'd0, 8'd0);
    send_request(ACT_TICK, 32'h7FFF_FFFF, 31'd0, 8'd0);
    send_request(ACT_ONCE, 32'd0, 31'h4000_0000, 8'hC3);
    send_request(ACT_TICK, 32'h8000_0000, 31'd0, 8'd0);

    now_ms  = 32'd1000;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) steady = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_request(ACT_UNUSED, $urandom, DELAY_W'($urandom), ID_W'($urandom));
      end else begin
        if (r < 45) begin
          // keep repeating slots rare: they never leave the table
          act = ($urandom_range(0, 24) == 0) ? ACT_REPEAT : ACT_ONCE;
          dr  = $urandom_range(0, 9);
          if (dr < 8) delay = DELAY_W'($urandom_range(0, 40));
          else if (dr == 8) delay = DELAY_W'($urandom);
          else delay = 31'h7FFF_FFFF - DELAY_W'($urandom_range(0, 3));
          send_request(act, now_ms, delay, ID_W'($urandom_range(0, 255)));
        end else begin
          if ($urandom_range(0, 19) == 0) now_ms = $urandom;
          else now_ms = now_ms + $urandom_range(0, 30);
          send_request(ACT_TICK, now_ms, DELAY_W'($urandom), ID_W'($urandom));
        end
        counted++;
      end
    end
    steady = 1'b0;
    req.valid <= 1'b0;

    // let the monitor note the final request before draining the results
    @(posedge clk_i);
    while (tracker.awaited_results.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 4) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
